// File: hw/rtl/clc_pkg.sv
// Shared types and constants of the connection limit counter.
// Used by clc_front, clc_back and connection_limit_counter; no dependencies.
`timescale 1ns / 1ps

package clc_pkg;

  localparam int unsigned CONN_ENTRIES = 256;
  localparam int unsigned HOST_ENTRIES = 64;
  localparam int unsigned USER_ENTRIES = 64;
  localparam int unsigned ID_BITS      = 32;

  localparam int unsigned CONN_AW = $clog2(CONN_ENTRIES);
  localparam int unsigned HOST_AW = $clog2(HOST_ENTRIES);
  localparam int unsigned USER_AW = $clog2(USER_ENTRIES);

  // One scan pass covers the largest of the three tables.
  localparam int unsigned SCAN_HU = (HOST_ENTRIES > USER_ENTRIES) ? HOST_ENTRIES : USER_ENTRIES;
  localparam int unsigned SCAN_N  = (CONN_ENTRIES > SCAN_HU) ? CONN_ENTRIES : SCAN_HU;
  localparam int unsigned SCAN_W  = $clog2(SCAN_N + 1);

  localparam int unsigned CNT_W = 16;

  typedef logic [ID_BITS-1:0] id_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  localparam cnt_t CNT_MAX = {CNT_W{1'b1}};
  localparam cnt_t CNT_ONE = cnt_t'(1);

  typedef enum logic [1:0] {
    CMD_CREATE  = 2'd0,
    CMD_APPROVE = 2'd1,
    CMD_CLOSE   = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_UNKNOWN = 2'd2
  } status_e;

  typedef enum logic {
    REG_HOST_LIMIT  = 1'b0,
    REG_TOTAL_LIMIT = 1'b1
  } reg_e;

  typedef struct packed {
    cmd_e cmd;
    id_t  conn;
    id_t  host;
    id_t  user;
    logic list_ok;
    logic enforce;
    cnt_t quota;
  } item_t;

  typedef struct packed {
    logic    allowed;
    logic    deny_total;
    logic    deny_host;
    logic    deny_user;
    logic    deny_list;
    logic    limit_report;
    status_e status;
    cnt_t    total_now;
  } res_t;

  // Handshake between the front queue and the back engine.
  typedef struct packed {
    logic  valid;
    item_t item;
  } fwd_t;

endpackage

// File: hw/rtl/clc_front.sv
// Front of the connection limit counter: accepts event words, decodes the
// command and holds them in a two-entry queue. Depends on clc_pkg.
`timescale 1ns / 1ps

module clc_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  logic [1:0]     cmd_i,
  input  logic [31:0]    conn_id_i,
  input  logic [31:0]    host_id_i,
  input  logic [31:0]    user_id_i,
  input  logic           host_list_ok_i,
  input  logic           enforce_user_quota_i,
  input  logic [15:0]    user_quota_i,
  output clc_pkg::fwd_t  fwd_o,
  input  logic           take_i
);

  clc_pkg::item_t ent_q [2];
  logic           wp_q, wp_d, rp_q, rp_d;
  logic [1:0]     cnt_q, cnt_d;
  clc_pkg::item_t in_item;
  logic           do_push, do_take;

  always_comb begin
    in_item = '0;
    unique case (cmd_i)
      clc_pkg::CMD_CREATE:  in_item.cmd = clc_pkg::CMD_CREATE;
      clc_pkg::CMD_APPROVE: in_item.cmd = clc_pkg::CMD_APPROVE;
      clc_pkg::CMD_CLOSE:   in_item.cmd = clc_pkg::CMD_CLOSE;
      default:              in_item.cmd = clc_pkg::CMD_NOP;
    endcase
    in_item.conn    = conn_id_i[clc_pkg::ID_BITS-1:0];
    in_item.host    = host_id_i[clc_pkg::ID_BITS-1:0];
    in_item.user    = user_id_i[clc_pkg::ID_BITS-1:0];
    in_item.list_ok = host_list_ok_i;
    in_item.enforce = enforce_user_quota_i;
    in_item.quota   = user_quota_i;
  end

  assign full_o  = (cnt_q == 2'd2);
  assign do_push = push_i && !full_o;
  assign do_take = take_i && (cnt_q != 2'd0);

  assign fwd_o.valid = (cnt_q != 2'd0);
  assign fwd_o.item  = ent_q[rp_q];

  always_comb begin
    wp_d  = do_push ? ~wp_q : wp_q;
    rp_d  = do_take ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wp_q] <= in_item;
    end
  end

endmodule

// File: hw/rtl/clc_back.sv
// Back of the connection limit counter: scans the connection, host and user
// tables, commits the event and queues the result word. Depends on clc_pkg.
`timescale 1ns / 1ps

module clc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  clc_pkg::fwd_t fwd_i,
  output logic          take_o,
  input  logic          cfg_valid_i,
  input  logic          cfg_index_i,
  input  logic [15:0]   cfg_data_i,
  output clc_pkg::res_t res_o,
  output logic          empty_o,
  input  logic          pop_i
);

  localparam int unsigned HW = clc_pkg::ID_BITS + clc_pkg::CNT_W;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_COMMIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Key and count memories.
  clc_pkg::id_t cmem [clc_pkg::CONN_ENTRIES];
  logic [HW-1:0] hmem [clc_pkg::HOST_ENTRIES];
  logic [HW-1:0] umem [clc_pkg::USER_ENTRIES];
  clc_pkg::id_t  crd_q;
  logic [HW-1:0] hrd_q, urd_q;

  logic                       cwe, hwe, uwe;
  logic [clc_pkg::CONN_AW-1:0] cwa;
  logic [clc_pkg::HOST_AW-1:0] hwa;
  logic [clc_pkg::USER_AW-1:0] uwa;
  clc_pkg::id_t               cwd;
  logic [HW-1:0]              hwd, uwd;

  logic [clc_pkg::CONN_ENTRIES-1:0] conn_valid_q, conn_valid_d;
  logic [clc_pkg::CONN_ENTRIES-1:0] conn_opened_q, conn_opened_d;
  logic [clc_pkg::HOST_ENTRIES-1:0] host_valid_q, host_valid_d;
  logic [clc_pkg::USER_ENTRIES-1:0] user_valid_q, user_valid_d;

  logic [clc_pkg::SCAN_W-1:0] scan_q, scan_d, idx_q, idx_d;
  logic                       rdv_q, rdv_d;

  clc_pkg::item_t item_q, item_d;

  logic                        c_hit_q, c_hit_d, c_free_q, c_free_d;
  logic [clc_pkg::CONN_AW-1:0] c_idx_q, c_idx_d, c_fidx_q, c_fidx_d;
  logic                        h_hit_q, h_hit_d, h_free_q, h_free_d;
  logic [clc_pkg::HOST_AW-1:0] h_idx_q, h_idx_d, h_fidx_q, h_fidx_d;
  clc_pkg::cnt_t               h_cnt_q, h_cnt_d;
  logic                        u_hit_q, u_hit_d, u_free_q, u_free_d;
  logic [clc_pkg::USER_AW-1:0] u_idx_q, u_idx_d, u_fidx_q, u_fidx_d;
  clc_pkg::cnt_t               u_cnt_q, u_cnt_d;

  clc_pkg::cnt_t total_q, total_d, host_limit_q, total_limit_q;

  clc_pkg::res_t res_q [2];
  logic          rwp_q, rwp_d, rrp_q, rrp_d;
  logic [1:0]    rcnt_q, rcnt_d;
  logic          push;
  clc_pkg::res_t res;

  logic                        in_c, in_h, in_u;
  logic [clc_pkg::CONN_AW-1:0] jc, csel;
  logic [clc_pkg::HOST_AW-1:0] jh;
  logic [clc_pkg::USER_AW-1:0] ju;
  clc_pkg::cnt_t               ucnt;
  logic                        full, ok_total, ok_host, ok_user;

  assign jc   = idx_q[clc_pkg::CONN_AW-1:0];
  assign jh   = idx_q[clc_pkg::HOST_AW-1:0];
  assign ju   = idx_q[clc_pkg::USER_AW-1:0];
  assign in_c = idx_q < clc_pkg::SCAN_W'(clc_pkg::CONN_ENTRIES);
  assign in_h = idx_q < clc_pkg::SCAN_W'(clc_pkg::HOST_ENTRIES);
  assign in_u = idx_q < clc_pkg::SCAN_W'(clc_pkg::USER_ENTRIES);
  assign csel = c_hit_q ? c_idx_q : c_fidx_q;

  always_comb begin
    state_d       = state_q;
    scan_d        = scan_q;
    item_d        = item_q;
    conn_valid_d  = conn_valid_q;
    conn_opened_d = conn_opened_q;
    host_valid_d  = host_valid_q;
    user_valid_d  = user_valid_q;
    c_hit_d = c_hit_q; c_idx_d = c_idx_q; c_free_d = c_free_q; c_fidx_d = c_fidx_q;
    h_hit_d = h_hit_q; h_idx_d = h_idx_q; h_free_d = h_free_q; h_fidx_d = h_fidx_q;
    h_cnt_d = h_cnt_q;
    u_hit_d = u_hit_q; u_idx_d = u_idx_q; u_free_d = u_free_q; u_fidx_d = u_fidx_q;
    u_cnt_d = u_cnt_q;
    total_d = total_q;
    take_o  = 1'b0;
    push    = 1'b0;
    cwe = 1'b0; cwa = csel;    cwd = item_q.conn;
    hwe = 1'b0; hwa = h_idx_q; hwd = '0;
    uwe = 1'b0; uwa = u_idx_q; uwd = '0;
    ucnt     = clc_pkg::CNT_ONE;
    full     = 1'b0;
    ok_total = 1'b1;
    ok_host  = 1'b1;
    ok_user  = 1'b1;
    res      = '0;

    rdv_d = (state_q == ST_SCAN) && (scan_q < clc_pkg::SCAN_W'(clc_pkg::SCAN_N));
    idx_d = scan_q;

    unique case (state_q)
      ST_IDLE: begin
        // Start only with room for the result word.
        if (fwd_i.valid && rcnt_q != 2'd2) begin
          take_o   = 1'b1;
          item_d   = fwd_i.item;
          scan_d   = '0;
          c_hit_d  = 1'b0; c_free_d = 1'b0;
          h_hit_d  = 1'b0; h_free_d = 1'b0;
          u_hit_d  = 1'b0; u_free_d = 1'b0;
          state_d  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_q < clc_pkg::SCAN_W'(clc_pkg::SCAN_N)) begin
          scan_d = scan_q + 1'b1;
        end else if (!rdv_q) begin
          state_d = ST_COMMIT;
        end
        if (rdv_q) begin
          if (in_c && conn_valid_q[jc] && crd_q == item_q.conn && !c_hit_q) begin
            c_hit_d = 1'b1; c_idx_d = jc;
          end
          if (in_c && !conn_valid_q[jc] && !c_free_q) begin
            c_free_d = 1'b1; c_fidx_d = jc;
          end
          if (in_h && host_valid_q[jh] && hrd_q[HW-1:clc_pkg::CNT_W] == item_q.host
              && !h_hit_q) begin
            h_hit_d = 1'b1; h_idx_d = jh; h_cnt_d = hrd_q[clc_pkg::CNT_W-1:0];
          end
          if (in_h && !host_valid_q[jh] && !h_free_q) begin
            h_free_d = 1'b1; h_fidx_d = jh;
          end
          if (in_u && user_valid_q[ju] && urd_q[HW-1:clc_pkg::CNT_W] == item_q.user
              && !u_hit_q) begin
            u_hit_d = 1'b1; u_idx_d = ju; u_cnt_d = urd_q[clc_pkg::CNT_W-1:0];
          end
          if (in_u && !user_valid_q[ju] && !u_free_q) begin
            u_free_d = 1'b1; u_fidx_d = ju;
          end
        end
      end
      ST_COMMIT: begin
        push    = 1'b1;
        state_d = ST_IDLE;
        case (item_q.cmd)
          clc_pkg::CMD_CREATE: begin
            if (total_q != clc_pkg::CNT_MAX) total_d = total_q + 1'b1;
            if (c_hit_q || c_free_q) begin
              conn_valid_d[csel]  = 1'b1;
              conn_opened_d[csel] = 1'b0;
              cwe = 1'b1;
            end else begin
              full = 1'b1;
            end
            if (h_hit_q) begin
              hwe = 1'b1;
              hwd = {item_q.host,
                     (h_cnt_q == clc_pkg::CNT_MAX) ? h_cnt_q : h_cnt_q + 1'b1};
            end else if (h_free_q) begin
              host_valid_d[h_fidx_q] = 1'b1;
              hwe = 1'b1; hwa = h_fidx_q;
              hwd = {item_q.host, clc_pkg::CNT_ONE};
            end else begin
              full = 1'b1;
            end
          end
          clc_pkg::CMD_APPROVE: begin
            if (c_hit_q) begin
              conn_opened_d[c_idx_q] = 1'b1;
            end else if (c_free_q) begin
              conn_valid_d[c_fidx_q]  = 1'b1;
              conn_opened_d[c_fidx_q] = 1'b0;
              cwe = 1'b1;
            end else begin
              full = 1'b1;
            end
            if (total_limit_q != '0) ok_total = total_q <= total_limit_q;
            if (host_limit_q != '0 && h_hit_q) ok_host = h_cnt_q <= host_limit_q;
            if (u_hit_q) begin
              ucnt = (u_cnt_q == clc_pkg::CNT_MAX) ? u_cnt_q : u_cnt_q + 1'b1;
              uwe  = 1'b1;
              uwd  = {item_q.user, ucnt};
            end else if (u_free_q) begin
              user_valid_d[u_fidx_q] = 1'b1;
              uwe = 1'b1; uwa = u_fidx_q;
              uwd = {item_q.user, clc_pkg::CNT_ONE};
            end else begin
              full = 1'b1;
            end
            if (item_q.enforce) ok_user = ucnt <= item_q.quota;
          end
          clc_pkg::CMD_CLOSE: begin
            if (c_hit_q) begin
              if (conn_opened_q[c_idx_q] && u_hit_q) begin
                if (u_cnt_q <= clc_pkg::CNT_ONE) begin
                  user_valid_d[u_idx_q] = 1'b0;
                end else begin
                  uwe = 1'b1;
                  uwd = {item_q.user, u_cnt_q - 1'b1};
                end
              end
              if (h_hit_q) begin
                if (h_cnt_q <= clc_pkg::CNT_ONE) begin
                  host_valid_d[h_idx_q] = 1'b0;
                end else begin
                  hwe = 1'b1;
                  hwd = {item_q.host, h_cnt_q - 1'b1};
                end
              end
              conn_valid_d[c_idx_q]  = 1'b0;
              conn_opened_d[c_idx_q] = 1'b0;
            end
            if (total_q != '0) total_d = total_q - 1'b1;
          end
          default: ;
        endcase
        res.deny_total   = !ok_total;
        res.deny_host    = !ok_host;
        res.deny_user    = !ok_user;
        res.deny_list    = (item_q.cmd == clc_pkg::CMD_APPROVE) && !item_q.list_ok;
        res.allowed      = ok_total && ok_host && ok_user && !res.deny_list;
        res.limit_report = (item_q.cmd == clc_pkg::CMD_APPROVE) && !res.allowed;
        if (item_q.cmd == clc_pkg::CMD_CLOSE && !c_hit_q) begin
          res.status = clc_pkg::STAT_UNKNOWN;
        end else if (full) begin
          res.status = clc_pkg::STAT_FULL;
        end else begin
          res.status = clc_pkg::STAT_OK;
        end
        res.total_now = total_d;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Result queue.
  logic do_pop;
  assign do_pop  = pop_i && (rcnt_q != 2'd0);
  assign empty_o = (rcnt_q == 2'd0);
  assign res_o   = res_q[rrp_q];

  always_comb begin
    rwp_d  = push ? ~rwp_q : rwp_q;
    rrp_d  = do_pop ? ~rrp_q : rrp_q;
    rcnt_d = rcnt_q + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      scan_q        <= '0;
      idx_q         <= '0;
      rdv_q         <= 1'b0;
      conn_valid_q  <= '0;
      conn_opened_q <= '0;
      host_valid_q  <= '0;
      user_valid_q  <= '0;
      total_q       <= '0;
      host_limit_q  <= '0;
      total_limit_q <= '0;
      rwp_q         <= 1'b0;
      rrp_q         <= 1'b0;
      rcnt_q        <= 2'd0;
    end else begin
      state_q       <= state_d;
      scan_q        <= scan_d;
      idx_q         <= idx_d;
      rdv_q         <= rdv_d;
      conn_valid_q  <= conn_valid_d;
      conn_opened_q <= conn_opened_d;
      host_valid_q  <= host_valid_d;
      user_valid_q  <= user_valid_d;
      total_q       <= total_d;
      rwp_q         <= rwp_d;
      rrp_q         <= rrp_d;
      rcnt_q        <= rcnt_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          clc_pkg::REG_HOST_LIMIT:  host_limit_q  <= cfg_data_i;
          clc_pkg::REG_TOTAL_LIMIT: total_limit_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    c_hit_q  <= c_hit_d;  c_idx_q <= c_idx_d;  c_free_q <= c_free_d;  c_fidx_q <= c_fidx_d;
    h_hit_q  <= h_hit_d;  h_idx_q <= h_idx_d;  h_free_q <= h_free_d;  h_fidx_q <= h_fidx_d;
    h_cnt_q  <= h_cnt_d;
    u_hit_q  <= u_hit_d;  u_idx_q <= u_idx_d;  u_free_q <= u_free_d;  u_fidx_q <= u_fidx_d;
    u_cnt_q  <= u_cnt_d;
    if (push) res_q[rwp_q] <= res;
  end

  always_ff @(posedge clk_i) begin
    if (cwe) cmem[cwa] <= cwd;
    crd_q <= cmem[scan_q[clc_pkg::CONN_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (hwe) hmem[hwa] <= hwd;
    hrd_q <= hmem[scan_q[clc_pkg::HOST_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (uwe) umem[uwa] <= uwd;
    urd_q <= umem[scan_q[clc_pkg::USER_AW-1:0]];
  end

endmodule

// File: hw/rtl/connection_limit_counter.sv
// Top level of the connection limit counter: front queue plus table engine.
// Depends on clc_pkg, clc_front and clc_back.
//
// Usage: event words enter through push/full; a word is taken at a clock
// edge with push high and full low. Results leave through empty/pop;
// the oldest result is on the result ports while empty is low and is
// consumed at an edge with pop high. The limit registers are written over
// cfg_valid/cfg_ready (always ready), index 0 host limit, 1 total limit.
// Events are handled one at a time: the engine scans all key memories one
// entry per cycle through their single read port, then commits the event in
// ST_COMMIT. The front queue holds two words and the result queue two words,
// so input and output stall independently; when the result queue is full the
// engine waits before starting the next word.
// Reset clears all valid marks, the total count, the limits and both queues;
// no clearing pass is needed.
`timescale 1ns / 1ps

module connection_limit_counter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] conn_id_i,
  input  logic [31:0] host_id_i,
  input  logic [31:0] user_id_i,
  input  logic        host_list_ok_i,
  input  logic        enforce_user_quota_i,
  input  logic [15:0] user_quota_i,
  output logic        empty,
  input  logic        pop,
  output logic        allowed_o,
  output logic        deny_total_o,
  output logic        deny_host_o,
  output logic        deny_user_o,
  output logic        deny_list_o,
  output logic        limit_report_o,
  output logic [1:0]  status_o,
  output logic [15:0] total_now_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  clc_pkg::fwd_t fwd;
  logic          take;
  clc_pkg::res_t res;

  assign cfg_ready = 1'b1;

  clc_front u_front (
    .clk_i,
    .rst_ni,
    .push_i               (push),
    .full_o               (full),
    .cmd_i,
    .conn_id_i,
    .host_id_i,
    .user_id_i,
    .host_list_ok_i,
    .enforce_user_quota_i,
    .user_quota_i,
    .fwd_o                (fwd),
    .take_i               (take)
  );

  clc_back u_back (
    .clk_i,
    .rst_ni,
    .fwd_i       (fwd),
    .take_o      (take),
    .cfg_valid_i (cfg_valid),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .res_o       (res),
    .empty_o     (empty),
    .pop_i       (pop)
  );

  assign allowed_o      = res.allowed;
  assign deny_total_o   = res.deny_total;
  assign deny_host_o    = res.deny_host;
  assign deny_user_o    = res.deny_user;
  assign deny_list_o    = res.deny_list;
  assign limit_report_o = res.limit_report;
  assign status_o       = res.status;
  assign total_now_o    = res.total_now;

endmodule

// File: sim/tb_connection_limit_counter.sv
// Self-checking testbench of the connection limit counter.
// Depends on clc_pkg and connection_limit_counter; compares every result word
// against a built-in model of the keyed count tables.
`timescale 1ns / 1ps

module tb_connection_limit_counter;

  localparam int unsigned WATCH_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  cmd_i = '0;
  logic [31:0] conn_id_i = '0;
  logic [31:0] host_id_i = '0;
  logic [31:0] user_id_i = '0;
  logic        host_list_ok_i = 1'b0;
  logic        enforce_user_quota_i = 1'b0;
  logic [15:0] user_quota_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        allowed_o, deny_total_o, deny_host_o, deny_user_o, deny_list_o;
  logic        limit_report_o;
  logic [1:0]  status_o;
  logic [15:0] total_now_o;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  connection_limit_counter dut (.*);

  // Model state; sized at the start of the run.
  clc_pkg::id_t  m_conn_key [];
  bit            m_conn_ok  [];
  bit            m_conn_open[];
  clc_pkg::id_t  m_host_key [];
  bit            m_host_ok  [];
  clc_pkg::cnt_t m_host_cnt [];
  clc_pkg::id_t  m_user_key [];
  bit            m_user_ok  [];
  clc_pkg::cnt_t m_user_cnt [];
  clc_pkg::cnt_t m_total;
  clc_pkg::cnt_t m_host_limit, m_total_limit;

  clc_pkg::item_t pending_events[$];
  clc_pkg::res_t  expected_verdicts[$];
  int    send_idle_pct, recv_idle_pct;
  bit    failed;
  int    quiet_cycles;

  function automatic int find_key(ref clc_pkg::id_t keys[], ref bit ok[],
                                  input clc_pkg::id_t key);
    for (int i = 0; i < keys.size(); i++)
      if (ok[i] && keys[i] == key) return i;
    return -1;
  endfunction

  function automatic int first_free(ref bit ok[]);
    for (int i = 0; i < ok.size(); i++)
      if (!ok[i]) return i;
    return -1;
  endfunction

  function automatic clc_pkg::cnt_t bump_count(ref clc_pkg::id_t keys[], ref bit ok[],
                                               ref clc_pkg::cnt_t cnt[],
                                               input clc_pkg::id_t key, inout bit tbl_full);
    int i;
    i = find_key(keys, ok, key);
    if (i >= 0) begin
      if (cnt[i] != clc_pkg::CNT_MAX) cnt[i] = cnt[i] + 1;
      return cnt[i];
    end
    i = first_free(ok);
    if (i < 0) begin
      tbl_full = 1'b1;
      return clc_pkg::CNT_ONE;
    end
    ok[i] = 1'b1;
    keys[i] = key;
    cnt[i] = clc_pkg::CNT_ONE;
    return clc_pkg::CNT_ONE;
  endfunction

  function automatic void drop_count(ref clc_pkg::id_t keys[], ref bit ok[],
                                     ref clc_pkg::cnt_t cnt[], input clc_pkg::id_t key);
    int i;
    i = find_key(keys, ok, key);
    if (i < 0) return;
    if (cnt[i] <= clc_pkg::CNT_ONE) ok[i] = 1'b0;
    else cnt[i] = cnt[i] - 1;
  endfunction

  function automatic void record_conn(clc_pkg::id_t key, inout bit tbl_full);
    int i;
    i = find_key(m_conn_key, m_conn_ok, key);
    if (i < 0) i = first_free(m_conn_ok);
    if (i < 0) tbl_full = 1'b1;
    else begin
      m_conn_ok[i] = 1'b1;
      m_conn_key[i] = key;
      m_conn_open[i] = 1'b0;
    end
  endfunction

  function automatic clc_pkg::res_t admit_event(clc_pkg::item_t it);
    clc_pkg::res_t r;
    bit ok_total, ok_host, ok_user, ok_list, tbl_full;
    clc_pkg::cnt_t ucount;
    int i;
    ok_total = 1; ok_host = 1; ok_user = 1; ok_list = 1; tbl_full = 0;
    r = '0;
    r.status = clc_pkg::STAT_OK;
    case (it.cmd)
      clc_pkg::CMD_CREATE: begin
        if (m_total != clc_pkg::CNT_MAX) m_total = m_total + 1;
        record_conn(it.conn, tbl_full);
        void'(bump_count(m_host_key, m_host_ok, m_host_cnt, it.host, tbl_full));
        if (tbl_full) r.status = clc_pkg::STAT_FULL;
      end
      clc_pkg::CMD_APPROVE: begin
        i = find_key(m_conn_key, m_conn_ok, it.conn);
        if (i >= 0) m_conn_open[i] = 1'b1;
        else record_conn(it.conn, tbl_full);
        ok_list = it.list_ok;
        if (m_total_limit != 0) ok_total = m_total <= m_total_limit;
        if (m_host_limit != 0) begin
          i = find_key(m_host_key, m_host_ok, it.host);
          if (i >= 0) ok_host = m_host_cnt[i] <= m_host_limit;
        end
        ucount = bump_count(m_user_key, m_user_ok, m_user_cnt, it.user, tbl_full);
        if (it.enforce) ok_user = ucount <= it.quota;
        if (tbl_full) r.status = clc_pkg::STAT_FULL;
      end
      clc_pkg::CMD_CLOSE: begin
        i = find_key(m_conn_key, m_conn_ok, it.conn);
        if (i >= 0) begin
          if (m_conn_open[i]) drop_count(m_user_key, m_user_ok, m_user_cnt, it.user);
          drop_count(m_host_key, m_host_ok, m_host_cnt, it.host);
          m_conn_ok[i] = 1'b0;
          m_conn_open[i] = 1'b0;
        end else r.status = clc_pkg::STAT_UNKNOWN;
        if (m_total != 0) m_total = m_total - 1;
      end
      default: ;
    endcase
    r.allowed = ok_list && ok_total && ok_host && ok_user;
    r.deny_total = !ok_total;
    r.deny_host = !ok_host;
    r.deny_user = !ok_user;
    r.deny_list = !ok_list;
    r.limit_report = (it.cmd == clc_pkg::CMD_APPROVE) && !r.allowed;
    r.total_now = m_total;
    return r;
  endfunction

  initial forever #10 clk_i = ~clk_i;

  // Event driver: offers the oldest word not yet accepted, idling at random, and drives pop at random.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (pending_events.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        push <= 1'b1;
        cmd_i <= pending_events[0].cmd;
        conn_id_i <= pending_events[0].conn;
        host_id_i <= pending_events[0].host;
        user_id_i <= pending_events[0].user;
        host_list_ok_i <= pending_events[0].list_ok;
        enforce_user_quota_i <= pending_events[0].enforce;
        user_quota_i <= pending_events[0].quota;
      end else push <= 1'b0;
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: acceptance of words on both sides and the watchdog.
  // The model runs at acceptance, in order.
  always @(posedge clk_i) begin
    clc_pkg::res_t want;
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (push && !full) begin
        expected_verdicts.push_back(admit_event(pending_events.pop_front()));
      end
      if (pop && !empty) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t: result word with nothing expected, actual %b%b%b%b%b%b %0d %0d",
                   $time, allowed_o, deny_total_o, deny_host_o, deny_user_o,
                   deny_list_o, limit_report_o, status_o, total_now_o);
          failed = 1'b1;
        end else begin
          want = expected_verdicts.pop_front();
          if (want !== {allowed_o, deny_total_o, deny_host_o, deny_user_o, deny_list_o,
                        limit_report_o, status_o, total_now_o}) begin
            $display("%0t: mismatch expected a=%b dt=%b dh=%b du=%b dl=%b r=%b st=%0d tot=%0d",
                     $time, want.allowed, want.deny_total, want.deny_host, want.deny_user,
                     want.deny_list, want.limit_report, want.status, want.total_now);
            $display("%0t:          actual   a=%b dt=%b dh=%b du=%b dl=%b r=%b st=%0d tot=%0d",
                     $time, allowed_o, deny_total_o, deny_host_o, deny_user_o,
                     deny_list_o, limit_report_o, status_o, total_now_o);
            failed = 1'b1;
          end
        end
      end
      if (quiet_cycles >= WATCH_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic add_event(clc_pkg::cmd_e c, clc_pkg::id_t cn, clc_pkg::id_t h,
                           clc_pkg::id_t u, bit lok, bit enf, clc_pkg::cnt_t q);
    clc_pkg::item_t it;
    it.cmd = c; it.conn = cn; it.host = h; it.user = u;
    it.list_ok = lok; it.enforce = enf; it.quota = q;
    pending_events.push_back(it);
  endtask

  task automatic drain_all();
    while (pending_events.size() > 0 || expected_verdicts.size() > 0) @(posedge clk_i);
  endtask

  task automatic write_limit(clc_pkg::reg_e idx, clc_pkg::cnt_t val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
    if (idx == clc_pkg::REG_HOST_LIMIT) m_host_limit = val;
    else m_total_limit = val;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Mostly a connection life: create, approve, maybe a second approve, maybe close; else one random event.
  // Ids come from small pools so that tables fill and counts collide.
  task automatic add_random_events(int n);
    clc_pkg::id_t cn, h, u;
    int r;
    for (int k = 0; k < n; ) begin
      cn = $urandom_range(3) == 0 ? $urandom : $urandom_range(300);
      h = $urandom_range(7) == 0 ? $urandom : $urandom_range(80);
      u = $urandom_range(7) == 0 ? $urandom : $urandom_range(80);
      r = $urandom_range(99);
      if (r < 70) begin
        add_event(clc_pkg::CMD_CREATE, cn, h, u, 1, 0, 0);
        add_event(clc_pkg::CMD_APPROVE, cn, h, u, $urandom_range(9) != 0, $urandom_range(1),
                  $urandom_range(3) == 0 ? $urandom : $urandom_range(4));
        if ($urandom_range(4) == 0)
          add_event(clc_pkg::CMD_APPROVE, cn, h, u, $urandom_range(1), $urandom_range(1),
                    $urandom);
        if ($urandom_range(9) < 6)
          add_event(clc_pkg::CMD_CLOSE, cn, h, u, $urandom, $urandom, $urandom);
        k += 3;
      end else begin
        add_event(clc_pkg::cmd_e'($urandom_range(3)), cn, h, u, $urandom_range(1),
                  $urandom_range(1), $urandom);
        k++;
      end
    end
  endtask

  initial begin
    m_conn_key  = new[clc_pkg::CONN_ENTRIES];
    m_conn_ok   = new[clc_pkg::CONN_ENTRIES];
    m_conn_open = new[clc_pkg::CONN_ENTRIES];
    m_host_key  = new[clc_pkg::HOST_ENTRIES];
    m_host_ok   = new[clc_pkg::HOST_ENTRIES];
    m_host_cnt  = new[clc_pkg::HOST_ENTRIES];
    m_user_key  = new[clc_pkg::USER_ENTRIES];
    m_user_ok   = new[clc_pkg::USER_ENTRIES];
    m_user_cnt  = new[clc_pkg::USER_ENTRIES];
    foreach (m_conn_ok[i]) begin m_conn_ok[i] = 0; m_conn_open[i] = 0; end
    foreach (m_host_ok[i]) m_host_ok[i] = 0;
    foreach (m_user_ok[i]) m_user_ok[i] = 0;
    m_total = 0; m_host_limit = 0; m_total_limit = 0;
    failed = 0; quiet_cycles = 0;
    send_idle_pct = 9; recv_idle_pct = 78;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Directed: every command, extremes of the fields, unknown close, repeated approve.
    write_limit(clc_pkg::REG_HOST_LIMIT, 16'd1);
    write_limit(clc_pkg::REG_TOTAL_LIMIT, 16'd2);
    add_event(clc_pkg::CMD_CLOSE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 16'hFFFF);
    add_event(clc_pkg::CMD_NOP, 32'h0, 32'h0, 32'h0, 0, 0, 16'h0);
    add_event(clc_pkg::CMD_APPROVE, 32'h5, 32'h7, 32'h9, 1, 1, 16'h0);
    add_event(clc_pkg::CMD_CREATE, 32'h0, 32'hFFFF_FFFF, 32'h0, 1, 0, 0);
    add_event(clc_pkg::CMD_CREATE, 32'h1, 32'hFFFF_FFFF, 32'h0, 1, 0, 0);
    add_event(clc_pkg::CMD_CREATE, 32'h0, 32'hFFFF_FFFF, 32'h0, 1, 0, 0);
    add_event(clc_pkg::CMD_APPROVE, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1, 16'h1);
    add_event(clc_pkg::CMD_APPROVE, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 16'h1);
    add_event(clc_pkg::CMD_APPROVE, 32'h0, 32'h1234, 32'hFFFF_FFFF, 1, 1, 16'hFFFF);
    add_event(clc_pkg::CMD_CLOSE, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 0);
    add_event(clc_pkg::CMD_CLOSE, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 0);
    add_event(clc_pkg::CMD_CLOSE, 32'h1, 32'hFFFF_FFFF, 32'h0, 1, 1, 0);
    add_event(clc_pkg::CMD_CLOSE, 32'h5, 32'h7, 32'h9, 1, 1, 0);
    add_event(clc_pkg::CMD_CLOSE, 32'h7, 32'h7, 32'h9, 1, 1, 0);
    // Hold off until the directed words have all come back.
    drain_all();

    write_limit(clc_pkg::REG_HOST_LIMIT, 16'hFFFF);
    write_limit(clc_pkg::REG_TOTAL_LIMIT, 16'h0);
    add_random_events(450);
    drain_all();

    send_idle_pct = 78; recv_idle_pct = 9;
    write_limit(clc_pkg::REG_HOST_LIMIT, 16'd2);
    write_limit(clc_pkg::REG_TOTAL_LIMIT, 16'd40);
    add_random_events(450);
    drain_all();

    send_idle_pct = 0; recv_idle_pct = 0;
    write_limit(clc_pkg::REG_HOST_LIMIT, 16'h0);
    write_limit(clc_pkg::REG_TOTAL_LIMIT, 16'hFFFF);
    add_random_events(450);
    drain_all();
    repeat (600) @(posedge clk_i);

    if (!failed && expected_verdicts.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: connection_limit_counter.f
hw/rtl/clc_pkg.sv
hw/rtl/clc_front.sv
hw/rtl/clc_back.sv
hw/rtl/connection_limit_counter.sv
sim/tb_connection_limit_counter.sv
